// ===== hdl/dj7seg_pkg.sv =====
// ----------------------------------------------------------------------------
// dj7seg_pkg: shared types and constants
// Work item format, register indexes and the seven-segment table used by
// the front end, the work queue and the digit sequencer.
// ----------------------------------------------------------------------------
package dj7seg_pkg;

    localparam int VALUE_W     = 10;
    localparam int SAMPLE_W    = 8;
    localparam int POS_W       = 2;
    localparam int SEG_W       = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VALUE_W-1:0] FULL_SCALE      = 10'd1023;
    localparam logic [VALUE_W-1:0] DEADBAND_RESET  = 10'd15;
    localparam logic [VALUE_W-1:0] CLAMP_RESET     = 10'd1010;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP    = 8'd1;

    // one classified item: value to show and index of its top shown digit
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   last_pos;
    } t_work;

    // active-low segments, bit0 = a .. bit7 = h
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] p;
        case (d)
            4'd0:    p = 8'hC0;
            4'd1:    p = 8'hF9;
            4'd2:    p = 8'hA4;
            4'd3:    p = 8'hB0;
            4'd4:    p = 8'h99;
            4'd5:    p = 8'h92;
            4'd6:    p = 8'h82;
            4'd7:    p = 8'hF8;
            4'd8:    p = 8'h80;
            4'd9:    p = 8'h90;
            default: p = 8'hFF;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/dj7seg_if.sv =====
// ----------------------------------------------------------------------------
// dj7seg_if: channel interfaces
// Sample input, digit output and configuration write channels.
// ----------------------------------------------------------------------------
interface dj7seg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_byte;

    modport source (output valid, output sample_byte, input ready);
    modport sink   (input valid, input sample_byte, output ready);
endinterface

interface dj7seg_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] digit_position;
    logic [7:0] segment_pattern;
    logic [9:0] shown_value;
    logic       last_digit;

    modport source (output valid, output digit_position, output segment_pattern,
                    output shown_value, output last_digit, input ready);
    modport sink   (input valid, input digit_position, input segment_pattern,
                    input shown_value, input last_digit, output ready);
endinterface

interface dj7seg_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/dejittered_four_digit_seven_segment.sv =====
// ----------------------------------------------------------------------------
// dejittered_four_digit_seven_segment: dejittered display driver
// Scales a received byte to ten bits, suppresses jitter against the held
// value, clamps near full scale and emits one segment pattern per digit.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                         transfer
//  -------  ---  ----------------------------------------------  -------------
//  i_in     in   sample_byte[7:0]                                valid & ready
//  o_out    out  digit_position, segment_pattern, shown_value,   valid & ready
//                last_digit
//  i_cfg    in   index[7:0] (0 deadband, 1 clamp), data[9:0]     valid & ready
//
//  A sample is taken whenever the two-entry work queue has room; the digit
//  sequencer then emits one output transfer per shown digit (1 to
//  DIGIT_COUNT), so the sustained rate is set by the digits per value.
//  Reset restores deadband 15, clamp 1010 and a zero held value.
//  A stalled output holds its digit; the queue lets new samples in meanwhile.
//  Config writes are always taken; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module dejittered_four_digit_seven_segment #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dj7seg_in_if.sink     i_in,
    dj7seg_cfg_if.sink    i_cfg,
    dj7seg_out_if.source  o_out
);
    import dj7seg_pkg::*;

    // front end to queue
    logic  push_valid;
    logic  push_ready;
    t_work push_data;

    // queue to digit sequencer
    logic  pop_valid;
    logic  pop_ready;
    t_work pop_data;

    // dejitter, clamp and digit-count classification
    dj7seg_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    // decouples sample intake from digit output
    dj7seg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    // one digit per unstalled cycle into a registered output
    dj7seg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

// ===== hdl/dj7seg_front.sv =====
// ----------------------------------------------------------------------------
// dj7seg_front: sample intake and dejitter
// Scales the sample, applies the deadband against the held value, clamps,
// and classifies the digit count before pushing into the work queue.
// ----------------------------------------------------------------------------
module dj7seg_front #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dj7seg_in_if.sink            i_in,
    dj7seg_cfg_if.sink           i_cfg,
    output logic                 o_push_valid,
    output dj7seg_pkg::t_work    o_push_data,
    input  logic                 i_push_ready
);
    import dj7seg_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(DIGIT_COUNT - 1);

    logic [VALUE_W-1:0] r_deadband;
    logic [VALUE_W-1:0] r_clamp;
    logic [VALUE_W-1:0] r_held;
    logic [VALUE_W-1:0] n_held;

    logic [VALUE_W-1:0] s;
    logic [VALUE_W-1:0] diff;
    logic [VALUE_W-1:0] res;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0]   top_pos;
    logic               take;

    assign s = {i_in.sample_byte, 2'b00};
    assign diff = (r_held >= s) ? (r_held - s) : (s - r_held);

    // full-scale sample cannot occur: s has its low two bits clear
    always_comb begin
        if (s == '0) begin
            res    = '0;
            n_held = '0;
        end else if (r_held == '0) begin
            res    = s;
            n_held = s;
        end else if (diff <= r_deadband) begin
            res    = r_held;
            n_held = r_held;
        end else begin
            res    = s;
            n_held = s;
        end
    end

    assign v = (res >= r_clamp) ? FULL_SCALE : res;

    always_comb begin
        if (v <= 10'd9) begin
            top_pos = 2'd0;
        end else if (v <= 10'd99) begin
            top_pos = 2'd1;
        end else if (v <= 10'd999) begin
            top_pos = 2'd2;
        end else begin
            top_pos = 2'd3;
        end
    end

    assign i_in.ready           = i_push_ready;
    assign take                 = i_in.valid && i_push_ready;
    assign o_push_valid         = i_in.valid;
    assign o_push_data.value    = v;
    assign o_push_data.last_pos = (top_pos > MAX_POS) ? MAX_POS : top_pos;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RESET;
            r_clamp    <= CLAMP_RESET;
            r_held     <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_DEADBAND: r_deadband <= i_cfg.data;
                    REG_CLAMP:    r_clamp    <= i_cfg.data;
                    default:      ;
                endcase
            end
            if (take) begin
                r_held <= n_held;
            end
        end
    end

endmodule

// ===== hdl/dj7seg_queue.sv =====
// ----------------------------------------------------------------------------
// dj7seg_queue: work queue
// Short FIFO of classified items between front end and digit sequencer.
// ----------------------------------------------------------------------------
module dj7seg_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    input  dj7seg_pkg::t_work    i_push_data,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output dj7seg_pkg::t_work    o_pop_data,
    input  logic                 i_pop_ready
);
    import dj7seg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_work            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != FULL_CNT);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/dj7seg_back.sv =====
// ----------------------------------------------------------------------------
// dj7seg_back: digit sequencer
// Peels one digit per unstalled cycle, units first, into the output register.
// ----------------------------------------------------------------------------
module dj7seg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pop_valid,
    input  dj7seg_pkg::t_work    i_pop_data,
    output logic                 o_pop_ready,
    dj7seg_out_if.source         o_out
);
    import dj7seg_pkg::*;

    logic               r_busy;
    logic [VALUE_W-1:0] r_rest;
    logic [VALUE_W-1:0] r_value;
    logic [POS_W-1:0]   r_last_pos;
    logic [POS_W-1:0]   r_k;

    logic               r_ov;
    logic [POS_W-1:0]   r_pos;
    logic [SEG_W-1:0]   r_seg;
    logic [VALUE_W-1:0] r_shown;
    logic               r_last;

    logic [17:0]        prod;
    logic [6:0]         quot;
    logic [VALUE_W-1:0] quot10;
    logic [VALUE_W-1:0] rem;
    logic               adv;
    logic               at_last;
    logic               pop;

    // x/10 as (x*205)>>11, exact for x below 1029
    assign prod    = 18'(r_rest) * 18'd205;
    assign quot    = prod[17:11];
    assign quot10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem     = r_rest - quot10;

    assign adv     = r_busy && (!r_ov || o_out.ready);
    assign at_last = (r_k == r_last_pos);
    assign o_pop_ready = !r_busy || (adv && at_last);
    assign pop     = i_pop_valid && o_pop_ready;

    assign o_out.valid           = r_ov;
    assign o_out.digit_position  = r_pos;
    assign o_out.segment_pattern = r_seg;
    assign o_out.shown_value     = r_shown;
    assign o_out.last_digit      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (adv) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (pop) begin
                r_busy <= 1'b1;
            end else if (adv && at_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pos   <= r_k;
            r_seg   <= seg_of(rem[3:0]);
            r_shown <= r_value;
            r_last  <= at_last;
            r_rest  <= {3'b000, quot};
            r_k     <= r_k + 1'b1;
        end
        if (pop) begin
            r_rest     <= i_pop_data.value;
            r_value    <= i_pop_data.value;
            r_last_pos <= i_pop_data.last_pos;
            r_k        <= '0;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the dejittered seven-segment display driver
// Drives received bytes through bursts and gaps, stalls the digit output on a
// changing pattern, predicts every digit transfer from the dejitter, clamp
// and digit split rules, and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import dj7seg_pkg::*;

    localparam int DIGITS       = 4;       // DIGIT_COUNT of the instance
    localparam int IDLE_TAIL    = 16;      // cycles past the last digit
    localparam int LONG_HOLD    = 200;     // output hold-off for back-pressure
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;

    // active-low patterns for digits 0..9
    localparam logic [SEG_W-1:0] SEG_LUT [0:9] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    // receiver stall styles
    typedef enum int { STALL_NONE, STALL_MIXED, STALL_HEAVY } t_stall;

    // one digit transfer as seen on the output channel
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [SEG_W-1:0]   seg;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_digit;

    logic i_clk;
    logic i_rst_n;

    dj7seg_in_if  in_ch ();
    dj7seg_cfg_if cfg_ch ();
    dj7seg_out_if out_ch ();

    dejittered_four_digit_seven_segment #(
        .DIGIT_COUNT(DIGITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // ------------------------------------------------------------------------
    // Clock and cycle count
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Display model: own copy of registers and the held reading
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0] deadband_reg;
    logic [VALUE_W-1:0] clamp_reg;
    logic [VALUE_W-1:0] held_reading;

    t_digit pending_digits [$];     // digits still owed by the block
    int     mismatch_count = 0;

    // Dejitter one byte, clamp, split into digits and queue them units first.
    function automatic void predict_digits(input logic [SAMPLE_W-1:0] b);
        logic [VALUE_W-1:0] scaled;
        logic [VALUE_W-1:0] shown;
        logic [VALUE_W-1:0] diff;
        int                 rest;
        int                 n;
        t_digit             d;
        scaled = {b, 2'b00};
        if (scaled == '0) begin
            shown        = '0;
            held_reading = '0;
        end else if (scaled == FULL_SCALE) begin
            // cannot happen with a byte scaled by four, kept for completeness
            shown        = FULL_SCALE;
            held_reading = FULL_SCALE;
        end else if (held_reading == '0) begin
            shown        = scaled;
            held_reading = scaled;
        end else begin
            diff = (held_reading >= scaled) ? held_reading - scaled
                                            : scaled - held_reading;
            if (diff <= deadband_reg) begin
                shown = held_reading;
            end else begin
                shown        = scaled;
                held_reading = scaled;
            end
        end
        // clamp touches the shown value only
        if (shown >= clamp_reg) shown = FULL_SCALE;

        if (shown <= 9)        n = 1;
        else if (shown <= 99)  n = 2;
        else if (shown <= 999) n = 3;
        else                   n = 4;
        if (n > DIGITS) n = DIGITS;

        rest = int'(shown);
        for (int k = 0; k < n; k++) begin
            d.pos   = k[POS_W-1:0];
            d.seg   = SEG_LUT[rest % 10];
            d.value = shown;
            d.last  = (k == n - 1);
            rest    = rest / 10;
            pending_digits.push_back(d);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output checker: every digit transfer against the oldest prediction
    // ------------------------------------------------------------------------
    t_digit got_digit;
    t_digit want_digit;

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_digit = '{out_ch.digit_position, out_ch.segment_pattern,
                          out_ch.shown_value, out_ch.last_digit};
            if (pending_digits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("cycle %0d: unexpected digit pos %0d seg %h value %0d last %0b",
                             cycle_count, got_digit.pos, got_digit.seg,
                             got_digit.value, got_digit.last);
            end else begin
                want_digit = pending_digits.pop_front();
                if (got_digit !== want_digit) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"cycle %0d: got pos %0d seg %h value %0d last %0b,",
                                  " expected pos %0d seg %h value %0d last %0b"},
                                 cycle_count, got_digit.pos, got_digit.seg,
                                 got_digit.value, got_digit.last, want_digit.pos,
                                 want_digit.seg, want_digit.value, want_digit.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows a 32-bit mask that is redrawn each round;
    // a hold request forces a long hold-off counted here.
    // ------------------------------------------------------------------------
    t_stall      stall_mode = STALL_NONE;
    int          hold_req   = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    logic [31:0] stall_mask = '1;
    logic [4:0]  mask_bit   = '0;

    always @(posedge i_clk) begin
        mask_bit <= mask_bit + 1'b1;
        if (mask_bit == '0) begin
            case (stall_mode)
                STALL_NONE:  stall_mask <= '1;
                STALL_HEAVY: stall_mask <= $urandom & $urandom;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       stall_mask <= '1;                  // clean stretch
                        1:       stall_mask <= $urandom;
                        2:       stall_mask <= $urandom & $urandom;
                        default: stall_mask <= $urandom | $urandom;
                    endcase
                end
            endcase
        end
        if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            hold_left    <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= stall_mask[mask_bit];
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    bit                gaps_on    = 1'b0;
    int                burst_left = 0;
    logic [SAMPLE_W-1:0] last_byte = '0;

    // Offer one byte, predict on its transfer. Valid stays high when the
    // burst goes on, so the caller either sends again or quiets the input.
    task automatic send_reading(input logic [SAMPLE_W-1:0] b);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.sample_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_digits(b);
        last_byte = b;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 12);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Lower valid and let every owed digit out, plus a tail for stragglers.
    task automatic drain_display();
        in_ch.valid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    // Config write, held until the channel takes it; valid stays high.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == REG_DEADBAND)   deadband_reg = val;
        else if (idx == REG_CLAMP) clamp_reg    = val;
    endtask

    // Reprogram both registers on an idle block, optionally with a stray
    // write to an unknown index that must be dropped.
    task automatic program_display(input logic [VALUE_W-1:0] db,
                                   input logic [VALUE_W-1:0] cl,
                                   input bit stray);
        drain_display();
        write_reg(REG_DEADBAND, db);
        if (stray) write_reg(CFG_INDEX_W'($urandom_range(255, REG_CLAMP + 1)),
                             CFG_DATA_W'($urandom_range(0, 1023)));
        write_reg(REG_CLAMP, cl);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly small moves around the last byte so the deadband gets work;
    // the rest are zeros, top bytes and wide jumps.
    function automatic logic [SAMPLE_W-1:0] pick_reading();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8)       v = 0;
        else if (r < 14) v = 255;
        else if (r < 66) v = int'(last_byte) + $urandom_range(0, 10) - 5;
        else             v = $urandom_range(0, 255);
        if (v < 0)   v = 0;
        if (v > 255) v = 255;
        return v[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values of the registers: zero, clamp near full scale, all digit
    // counts, every segment pattern, jitter held and jumps taken.
    task automatic test_reset_defaults();
        logic [SAMPLE_W-1:0] seq [$];
        deadband_reg = DEADBAND_RESET;
        clamp_reg    = CLAMP_RESET;
        held_reading = '0;
        gaps_on = 1'b1;
        stall_mode <= STALL_MIXED;
        // 0, 1020 clamped, 8, 12 inside band, 100, 20, 0, 1000, 1008 held,
        // 4, 972, 568, 304
        seq = '{8'd0, 8'd255, 8'd2, 8'd3, 8'd25, 8'd5, 8'd0, 8'd250, 8'd252,
                8'd1, 8'd243, 8'd142, 8'd76};
        foreach (seq[i]) send_reading(seq[i]);
        drain_display();
    endtask

    // Register extremes: no deadband with everything clamped, then the widest
    // deadband with clamping out of reach; each setting has a stray index write.
    task automatic test_register_extremes();
        program_display(10'd0, 10'd0, 1'b1);
        send_reading(8'd1);
        send_reading(8'd1);
        send_reading(8'd128);
        send_reading(8'd0);
        program_display(10'd1023, 10'd1023, 1'b1);
        send_reading(8'd0);
        send_reading(8'd10);
        send_reading(8'd255);
        send_reading(8'd0);
        send_reading(8'd255);
        drain_display();
    endtask

    // Random phases, each with its own register setting, stall style and
    // sender pacing.
    task automatic test_random_phases();
        logic [VALUE_W-1:0] db;
        logic [VALUE_W-1:0] cl;
        for (int phase = 0; phase < 6; phase++) begin
            db = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(0, 1023))
                                             : VALUE_W'($urandom_range(0, 40));
            cl = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(0, 1023))
                                             : VALUE_W'($urandom_range(900, 1023));
            program_display(db, cl, 1'($urandom_range(0, 1)));
            stall_mode <= t_stall'(phase % 3);
            gaps_on = (phase != 2);
            repeat (55) send_reading(pick_reading());
            drain_display();
        end
    endtask

    // Output held off for a long stretch while bytes keep coming, so the
    // work queue fills and the input stalls.
    task automatic test_output_backpressure();
        program_display(VALUE_W'($urandom_range(0, 30)),
                        VALUE_W'($urandom_range(950, 1023)), 1'b0);
        stall_mode <= STALL_MIXED;
        gaps_on = 1'b0;
        hold_req <= hold_req + 1;
        repeat (40) send_reading(pick_reading());
        drain_display();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.sample_byte <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_phases();
        test_output_backpressure();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: a hung handshake or lost digits end the run here.
    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
